@@ rtl/skte_pkg.sv @@
// Package: shared constants, codes and controller/datapath interface types.
package skte_pkg;

    localparam int TABLES      = 32;
    localparam int SLOTS       = 64;
    localparam int KEY_BITS    = 16;
    localparam int HANDLE_BITS = 16;

    localparam int TSEL_W  = 5;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = 7;
    localparam int ADDR_W  = $clog2(TABLES) + SLOT_W;
    localparam int DEPTH   = TABLES * SLOTS;

    localparam logic [1:0] CMD_LOOKUP  = 2'd0;
    localparam logic [1:0] CMD_INSERT  = 2'd1;
    localparam logic [1:0] CMD_DEL_KEY = 2'd2;
    localparam logic [1:0] CMD_DEL_HDL = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request, clear index and match
        logic scan;      // scan phase: track count and position
        logic rd_en;     // issue read at scan index
        logic cmp;       // evaluate returned entry
        logic idx_inc;   // scan index + 1
        logic idx_dec;   // scan index - 1
        logic wr_en;     // write shift/insert data at write address
        logic wr_shift;  // 1: write moved entry, 0: write request pair
        logic wr_hdl;    // update handle only (insert hit)
        logic set_idx_n; // scan index <- count (insert shift start)
        logic cnt_inc;
        logic cnt_dec;
        logic rd_low;    // read entry 0 of table
        logic low_cap;   // capture lowest key
        logic out_load;  // load result register
    } skte_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic bad_tbl;
        logic scan_end;  // index reached count or slot limit
        logic hit;       // compared entry matches
        logic stop;      // compared key above request key
        logic full;      // count at limit
        logic at_pos;    // index equals position (shift done)
        logic del_end;   // index + 1 reached count
        logic matched;   // scan ended on a matching entry
        logic [1:0] cmd;
        logic out_busy;  // result register still held
    } skte_sts_t;

endpackage

@@ rtl/skte_ram.sv @@
// Generic simple dual-port RAM (one write, one read port) with registered read.
module skte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/skte_ctrl.sv @@
// Controller state machine for the sorted key table engine.
module skte_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  skte_pkg::skte_sts_t sts,
    output skte_pkg::skte_ctl_t ctl,
    output logic               busy
);
    import skte_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_DECIDE= 4'd3;
    localparam logic [3:0] S_ISH_R = 4'd4;
    localparam logic [3:0] S_ISH_W = 4'd5;
    localparam logic [3:0] S_INS_W = 4'd6;
    localparam logic [3:0] S_DSH_R = 4'd7;
    localparam logic [3:0] S_DSH_W = 4'd8;
    localparam logic [3:0] S_LOW_R = 4'd9;
    localparam logic [3:0] S_LOW_W = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_UPD   = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ctl = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctl.load = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                ctl.scan = 1'b1;
                if (sts.bad_tbl || sts.scan_end)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.scan = 1'b1;
                ctl.cmp = 1'b1;
                if (sts.hit || sts.stop)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next = S_RD;
                end
            end
            S_DECIDE:
            begin
                state_next = S_LOW_R;
                if (!sts.bad_tbl)
                begin
                    case (sts.cmd)
                        CMD_INSERT:
                        begin
                            if (sts.matched)
                            begin
                                state_next = S_UPD;
                            end
                            else if (!sts.full)
                            begin
                                ctl.set_idx_n = 1'b1;
                                state_next = S_ISH_R;
                            end
                        end
                        CMD_DEL_KEY, CMD_DEL_HDL:
                        begin
                            if (sts.matched)
                            begin
                                state_next = S_DSH_R;
                            end
                        end
                        default:
                        begin
                            state_next = S_LOW_R;
                        end
                    endcase
                end
            end
            S_UPD:
            begin
                ctl.wr_en = 1'b1;
                ctl.wr_hdl = 1'b1;
                state_next = S_LOW_R;
            end
            S_ISH_R:
            begin
                if (sts.at_pos)
                begin
                    state_next = S_INS_W;
                end
                else
                begin
                    ctl.rd_en = 1'b1; // reads index-1 in insert mode
                    state_next = S_ISH_W;
                end
            end
            S_ISH_W:
            begin
                ctl.wr_en = 1'b1;
                ctl.wr_shift = 1'b1;
                ctl.idx_dec = 1'b1;
                state_next = S_ISH_R;
            end
            S_INS_W:
            begin
                ctl.wr_en = 1'b1;
                ctl.cnt_inc = 1'b1;
                state_next = S_LOW_R;
            end
            S_DSH_R:
            begin
                if (sts.del_end)
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next = S_LOW_R;
                end
                else
                begin
                    ctl.rd_en = 1'b1; // reads index+1 in delete mode
                    state_next = S_DSH_W;
                end
            end
            S_DSH_W:
            begin
                ctl.wr_en = 1'b1;
                ctl.wr_shift = 1'b1;
                ctl.idx_inc = 1'b1;
                state_next = S_DSH_R;
            end
            S_LOW_R:
            begin
                ctl.rd_low = 1'b1;
                state_next = S_LOW_W;
            end
            S_LOW_W:
            begin
                ctl.low_cap = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> state_reg == S_IDLE)
        else $error("result load did not end item");
    a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_en && ctl.rd_en))
        else $error("read and write in one cycle");
`endif
endmodule

@@ rtl/skte_dp.sv @@
// Datapath: stores, scan index, compare, shift and result register.
module skte_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skte_pkg::skte_ctl_t           ctl,
    output skte_pkg::skte_sts_t           sts,
    input  logic [1:0]                    cmd,
    input  logic [skte_pkg::TSEL_W-1:0]   table_sel,
    input  logic [15:0]                   key,
    input  logic [15:0]                   handle_in,
    input  logic                          cfg_we,
    input  logic [skte_pkg::CNT_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [63:0]                   out_data
);
    import skte_pkg::*;

    localparam int TIDX_W = (TABLES > 1) ? $clog2(TABLES) : 1;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg [TABLES];

    logic [1:0]            cmd_reg;
    logic [TSEL_W-1:0]     tsel_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [HANDLE_BITS-1:0] hdl_reg;
    logic                  bad_reg;
    logic [CNT_W-1:0]      n_reg;     // count at start
    logic [CNT_W-1:0]      idx_reg;   // scan / shift index
    logic [CNT_W-1:0]      pos_reg;
    logic                  hit_reg;
    logic [HANDLE_BITS-1:0] hout_reg;
    logic [KEY_BITS-1:0]   low_reg;
    logic                  shift_dn_reg; // delete-shift mode
    logic                  ins_mode_reg;

    logic                  ov_reg;
    logic [63:0]           od_reg;
    logic [63:0]           od_next;

    logic [TIDX_W-1:0]     tix;
    logic [CNT_W-1:0]      n_now;
    logic [CNT_W-1:0]      lim;
    logic [CNT_W-1:0]      ridx;
    logic [CNT_W-1:0]      widx;
    logic [ADDR_W-1:0]     raddr, waddr;
    logic [KEY_BITS-1:0]   k_rd, k_wd;
    logic [HANDLE_BITS-1:0] h_rd, h_wd;
    logic                  k_we, re;
    logic                  hit_now, stop_now;

    assign tix = tsel_reg[TIDX_W-1:0];
    assign n_now = bad_reg ? '0 : count_reg[tix];
    assign lim = (cap_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cap_reg;

    // read index: scan = idx, insert shift = idx-1, delete shift = idx+1, low read = 0
    always_comb
    begin
        ridx = idx_reg;
        if (ins_mode_reg)
        begin
            ridx = idx_reg - 1'b1;
        end
        else if (shift_dn_reg)
        begin
            ridx = idx_reg + 1'b1;
        end
        if (ctl.rd_low)
        begin
            ridx = '0;
        end
    end
    assign widx = (ctl.wr_hdl || (!ctl.wr_shift)) ? pos_reg : idx_reg;
    assign raddr = {tix, ridx[SLOT_W-1:0]};
    assign waddr = {tix, widx[SLOT_W-1:0]};
    assign re = ctl.rd_en || ctl.rd_low;
    assign k_we = ctl.wr_en && !ctl.wr_hdl;
    assign k_wd = ctl.wr_shift ? k_rd : key_reg;
    assign h_wd = ctl.wr_shift ? h_rd : hdl_reg;

    skte_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
        .clk(clk), .we(k_we), .waddr(waddr), .wdata(k_wd),
        .re(re), .raddr(raddr), .rdata(k_rd));
    skte_ram #(.WIDTH(HANDLE_BITS), .DEPTH(DEPTH)) u_hdl_ram (
        .clk(clk), .we(ctl.wr_en), .waddr(waddr), .wdata(h_wd),
        .re(re), .raddr(raddr), .rdata(h_rd));

    assign hit_now  = (cmd_reg == CMD_DEL_HDL) ? (h_rd == hdl_reg) : (k_rd == key_reg);
    assign stop_now = (cmd_reg != CMD_DEL_HDL) && (k_rd > key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(64);
            for (int i = 0; i < TABLES; i++)
            begin
                count_reg[i] <= '0;
            end
            ov_reg <= 1'b0;
            shift_dn_reg <= 1'b0;
            ins_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (ctl.cnt_inc)
            begin
                count_reg[tix] <= n_reg + 1'b1;
            end
            else if (ctl.cnt_dec)
            begin
                count_reg[tix] <= n_reg - 1'b1;
            end
            if (ctl.load || ctl.rd_low)
            begin
                shift_dn_reg <= 1'b0;
                ins_mode_reg <= 1'b0;
            end
            else
            begin
                if (ctl.set_idx_n)
                begin
                    ins_mode_reg <= 1'b1;
                end
                if (sts.cmd != CMD_INSERT && hit_reg && !ctl.cmp)
                begin
                    shift_dn_reg <= 1'b1;
                end
            end
            if (ctl.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // result word, fields from bit 0 up
    always_comb
    begin
        od_next = '0;
        if (bad_reg)
        begin
            od_next[1:0] = ST_NOT_FOUND;
            od_next[49]  = 1'b1;
        end
        else
        begin
            od_next[1:0]   = (hit_reg) ? ST_OK :
                             (cmd_reg == CMD_INSERT && n_now == n_reg &&
                              (n_reg >= lim)) ? ST_FULL :
                             (cmd_reg == CMD_INSERT) ? ST_OK : ST_NOT_FOUND;
            od_next[2]     = hit_reg;
            od_next[18:3]  = (cmd_reg == CMD_DEL_HDL && hit_reg) ?
                             16'(hdl_reg) : 16'(hout_reg);
            od_next[25:19] = pos_reg;
            od_next[32:26] = n_now;
            od_next[48:33] = (n_now != '0) ? 16'(low_reg) : 16'd0;
            od_next[49]    = (n_now == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            tsel_reg <= table_sel;
            key_reg  <= key[KEY_BITS-1:0];
            hdl_reg  <= handle_in[HANDLE_BITS-1:0];
            bad_reg  <= (32'(table_sel) >= TABLES);
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            hout_reg <= '0;
        end
        else
        begin
            if (ctl.cmp)
            begin
                hit_reg <= hit_now;
                if (hit_now)
                begin
                    hout_reg <= h_rd;
                end
            end
            if (ctl.set_idx_n)
            begin
                idx_reg <= n_reg;
            end
            else if (ctl.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (ctl.idx_dec)
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
        // count and position are frozen once the scan ends
        if (ctl.scan)
        begin
            n_reg <= n_now;
            pos_reg <= idx_reg;
        end
        if (ctl.low_cap)
        begin
            low_reg <= k_rd;
        end
        if (ctl.out_load)
        begin
            od_reg <= od_next;
        end
    end

    assign sts.bad_tbl  = bad_reg;
    assign sts.scan_end = (idx_reg >= n_now) || (32'(idx_reg) >= SLOTS);
    assign sts.hit      = hit_now;
    assign sts.stop     = stop_now;
    assign sts.full     = (n_reg >= lim);
    assign sts.at_pos   = (idx_reg == pos_reg);
    assign sts.del_end  = (idx_reg + 1'b1 >= n_reg);
    assign sts.matched  = hit_reg;
    assign sts.cmd      = cmd_reg;
    assign sts.out_busy = ov_reg && !out_ready;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

`ifndef SYNTHESIS
    a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cnt_inc |-> n_reg < CNT_W'(SLOTS))
        else $error("count grows past slots");
    a_dec_nz: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cnt_dec |-> n_reg != '0)
        else $error("count drops below zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> $stable(od_reg))
        else $error("result changed while held");
`endif
endmodule

@@ rtl/sorted_key_table_engine.sv @@
// Top level of the sorted key table engine.
//
//  channel  | group                 | payload
//  ---------+-----------------------+-----------------------------------------
//  request  | s_tvalid/tready/tdata | cmd, table_sel, key, handle_in
//  result   | m_tvalid/tready/tdata | status, found, handle_out, position,
//           |                       | entry_total, lowest_key, table_empty
//  config   | cfg_we/cfg_data       | table_capacity
//
// One request at a time. A request for a table of n entries runs a linear
// scan through the registered RAM read, then, for an insert or delete, a shift
// pass over the moved entries, then a read of entry 0.
// Reset clears counts and sets capacity to 64; entries above count never reach the result.
// s_tready drops from acceptance until the result is loaded in the output
// register; a stalled result holds, and the next request can be taken meanwhile.
module sorted_key_table_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[1:0], table_sel[6:2], key[22:7], handle_in[38:23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[1:0], found[2], handle_out[18:3],
                                   // position[25:19], entry_total[32:26],
                                   // lowest_key[48:33], table_empty[49]
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data   // table_capacity
);
    import skte_pkg::*;

    skte_ctl_t ctl;
    skte_sts_t sts;
    logic      busy;
    logic      in_fire;
    logic [63:0] od;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;

    skte_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .sts(sts), .ctl(ctl), .busy(busy));

    skte_dp u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .cmd(s_tdata[1:0]), .table_sel(s_tdata[6:2]),
        .key(s_tdata[22:7]), .handle_in(s_tdata[38:23]),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(od));

    assign m_tdata = od[55:0];

`ifndef SYNTHESIS
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("second request accepted while busy");
    a_low_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[49] |-> m_tdata[48:26] == '0)
        else $error("empty table reports entries");
    a_pos_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:26] <= 7'd64)
        else $error("count out of range");
`endif
endmodule
